@@ src/spr_pkg.sv @@
// Shared types and constants of the eight-channel servo pulse ramp.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package spr_pkg;

  // Field and state widths.
  localparam int OPC_W   = 1;
  localparam int CHIN_W  = 4;
  localparam int OCH_W   = 3;
  localparam int PULSE_W = 12;
  localparam int MS_W    = 16;
  localparam int TIME_W  = 15;
  localparam int STEP_W  = 11;
  localparam int OFF_W   = 13;

  // Opcodes of an input beat.
  localparam logic [OPC_W-1:0] OP_SET  = 1'b0;
  localparam logic [OPC_W-1:0] OP_TICK = 1'b1;

  // Pulse and time limits.
  localparam logic [PULSE_W-1:0] PULSE_MIN   = 12'd500;
  localparam logic [PULSE_W-1:0] PULSE_MAX   = 12'd2500;
  localparam logic [PULSE_W-1:0] PULSE_RESET = 12'd1500;
  localparam logic [TIME_W-1:0]  TIME_MIN    = 15'd20;
  localparam logic [TIME_W-1:0]  TIME_MAX    = 15'd30000;

  // Division by the 20 ms tick period as a reciprocal multiply.
  // 52429 / 2^20 is slightly above 1/20, and the excess stays below one
  // twentieth over the clamped time range, so the floor is exact.
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] TICK_RECIP = 16'd52429;

  // Ramp divider: one quotient bit per cycle; the quotient is below 2^11.
  localparam int DIV_STEPS = STEP_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int DSR_W     = 2 * STEP_W;
  localparam int PROD_W    = OFF_W + STEP_W + 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_set;
    logic do_tick;
    logic do_mul;
    logic do_div;
    logic do_emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ src/spr_in_if.sv @@
// Input channel of the servo pulse ramp: valid, ready and one input beat.
// Depends on spr_pkg.
`default_nettype none

interface spr_in_if;
  import spr_pkg::*;

  logic               valid;
  logic               ready;
  logic [OPC_W-1:0]   opcode;
  logic [CHIN_W-1:0]  channel;
  logic [PULSE_W-1:0] pulse_us;
  logic [MS_W-1:0]    move_ms;

  modport source (output valid, opcode, channel, pulse_us, move_ms, input ready);
  modport sink   (input valid, opcode, channel, pulse_us, move_ms, output ready);
endinterface

`default_nettype wire

@@ src/spr_out_if.sv @@
// Result channel of the servo pulse ramp: valid, ready and one result beat.
// Depends on spr_pkg.
`default_nettype none

interface spr_out_if;
  import spr_pkg::*;

  logic               valid;
  logic               ready;
  logic [OCH_W-1:0]   out_channel;
  logic [PULSE_W-1:0] pulse_out;
  logic               last;
  logic               moving;

  modport source (output valid, out_channel, pulse_out, last, moving, input ready);
  modport sink   (input valid, out_channel, pulse_out, last, moving, output ready);
endinterface

`default_nettype wire

@@ src/spr_ctrl.sv @@
// Controller of the servo pulse ramp: accepts beats and sequences the
// per-channel multiply, divide and emit steps. Depends on spr_pkg.
`default_nettype none

module spr_ctrl #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [spr_pkg::OPC_W-1:0]   in_opcode,
  output logic                             in_ready,
  input  spr_pkg::dp_status_t              status,
  output spr_pkg::dp_cmd_t                 cmd,
  output logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] ch_idx
);
  import spr_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign ch_idx   = ch_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_TICK) begin
            cmd.do_tick = 1'b1;
            ch_nxt      = '0;
            state_nxt   = S_MUL;
          end else begin
            cmd.do_set = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        if (status.need_div) begin
          cnt_nxt   = DCNT_W'(DIV_STEPS - 1);
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        cmd.do_div = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.do_emit = 1'b1;
          if (ch_r == CH_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            ch_nxt    = CH_W'(ch_r + 1'b1);
            state_nxt = S_MUL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/spr_datapath.sv @@
// Datapath of the servo pulse ramp: channel pulse state, move timing,
// the ramp multiplier, a bit-serial divider and the result register.
// Depends on spr_pkg and spr_out_if.
`default_nettype none

module spr_datapath #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [spr_pkg::CHIN_W-1:0]   in_channel,
  input  wire logic [spr_pkg::PULSE_W-1:0]  in_pulse_us,
  input  wire logic [spr_pkg::MS_W-1:0]     in_move_ms,
  input  spr_pkg::dp_cmd_t                  cmd,
  input  wire logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] ch_idx,
  output spr_pkg::dp_status_t               status,
  spr_out_if.source                         out_b
);
  import spr_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

  // Per-channel state.
  logic [PULSE_W-1:0]      cur_r [NUM_CHANNELS];
  logic [PULSE_W-1:0]      tgt_r [NUM_CHANNELS];
  logic signed [OFF_W-1:0] off_r [NUM_CHANNELS];

  // Move state.
  logic [TIME_W-1:0] mt_r;
  logic [STEP_W-1:0] total_r;
  logic [STEP_W-1:0] sl_r;
  logic              pend_r;
  logic              run_r;
  logic              start_r;
  logic              adv_r;
  logic              fin_r;

  // Ramp arithmetic.
  logic [DSR_W-1:0] dsr_r;
  logic             neg_r;

  // Result register.
  logic               ovalid_r;
  logic [OCH_W-1:0]   och_r;
  logic [PULSE_W-1:0] opulse_r;
  logic               olast_r;
  logic               omoving_r;

  // Set beat checks and the clamped move time.
  logic              set_ok;
  logic [CH_W-1:0]   set_idx;
  logic [TIME_W-1:0] mt_clamped;

  assign set_ok  = (int'(in_channel) < NUM_CHANNELS) &&
                   (in_pulse_us >= PULSE_MIN) && (in_pulse_us <= PULSE_MAX);
  assign set_idx = CH_W'(in_channel);

  always_comb begin
    if (in_move_ms < MS_W'(TIME_MIN)) begin
      mt_clamped = TIME_MIN;
    end else if (in_move_ms > MS_W'(TIME_MAX)) begin
      mt_clamped = TIME_MAX;
    end else begin
      mt_clamped = TIME_W'(in_move_ms);
    end
  end

  // Step count of a new move and the step update of a tick.
  logic [TIME_W+RECIP_W-1:0] recip_prod;
  logic [STEP_W-1:0]         steps_calc;
  logic [STEP_W-1:0]         tot_eff;
  logic [STEP_W-1:0]         sl_base;
  logic [STEP_W-1:0]         sl_dec;
  logic                      run_eff;
  logic                      fin_now;

  assign recip_prod = mt_r * TICK_RECIP;
  assign steps_calc = recip_prod[RECIP_SHIFT +: STEP_W];
  assign tot_eff    = pend_r ? steps_calc : total_r;
  assign sl_base    = pend_r ? steps_calc : sl_r;
  assign run_eff    = pend_r || run_r;
  assign sl_dec     = (sl_base != '0) ? STEP_W'(sl_base - 1'b1) : '0;
  assign fin_now    = (sl_dec == '0) || (tot_eff == '0);

  // Channel read port and the offset times remaining steps.
  logic [PULSE_W-1:0]       cur_rd;
  logic [PULSE_W-1:0]       tgt_rd;
  logic signed [OFF_W-1:0]  off_now;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_abs;

  assign cur_rd  = cur_r[ch_idx];
  assign tgt_rd  = tgt_r[ch_idx];
  assign off_now = start_r ? ($signed({1'b0, cur_rd}) - $signed({1'b0, tgt_rd}))
                           : off_r[ch_idx];
  assign prod     = PROD_W'(off_now) * PROD_W'($signed({1'b0, sl_r}));
  assign prod_abs = prod[PROD_W-1] ? $unsigned(PROD_W'(-prod)) : $unsigned(prod);

  // One restoring divide step: remainder in the upper half, quotient
  // bits shift into the lower half.
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   diff;
  logic              ge;
  logic [STEP_W-1:0] rem_new;

  assign trial   = dsr_r[DSR_W-1:STEP_W-1];
  assign diff    = trial - {1'b0, total_r};
  assign ge      = (trial >= {1'b0, total_r});
  assign rem_new = ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];

  // New pulse of the channel.
  logic signed [OFF_W-1:0] q_signed;
  logic signed [OFF_W-1:0] ramp_sum;
  logic [PULSE_W-1:0]      new_pulse;

  assign q_signed = neg_r ? -$signed({2'b00, dsr_r[STEP_W-1:0]})
                          : $signed({2'b00, dsr_r[STEP_W-1:0]});
  assign ramp_sum = $signed({1'b0, tgt_rd}) + q_signed;

  always_comb begin
    if (!adv_r) begin
      new_pulse = cur_rd;
    end else if (fin_r) begin
      new_pulse = tgt_rd;
    end else begin
      new_pulse = ramp_sum[PULSE_W-1:0];
    end
  end

  assign status.need_div = adv_r && !fin_r;
  assign status.out_free = !ovalid_r || out_b.ready;

  // Channel arrays and move state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        cur_r[c] <= PULSE_RESET;
        tgt_r[c] <= PULSE_RESET;
        off_r[c] <= '0;
      end
      mt_r    <= TIME_MIN;
      total_r <= STEP_W'(1);
      sl_r    <= '0;
      pend_r  <= 1'b0;
      run_r   <= 1'b0;
      start_r <= 1'b0;
      adv_r   <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      if (cmd.do_set && set_ok) begin
        tgt_r[set_idx] <= in_pulse_us;
        mt_r           <= mt_clamped;
        pend_r         <= 1'b1;
      end
      if (cmd.do_tick) begin
        start_r <= pend_r;
        if (pend_r) begin
          pend_r  <= 1'b0;
          total_r <= steps_calc;
        end
        if (run_eff) begin
          sl_r  <= sl_dec;
          run_r <= !fin_now;
          adv_r <= 1'b1;
          fin_r <= fin_now;
        end else begin
          run_r <= 1'b0;
          adv_r <= 1'b0;
          fin_r <= 1'b0;
        end
      end
      if (cmd.do_mul && start_r) begin
        off_r[ch_idx] <= off_now;
      end
      if (cmd.do_emit) begin
        cur_r[ch_idx] <= new_pulse;
      end
    end
  end

  // Multiply and divide registers.
  always_ff @(posedge clk) begin
    if (cmd.do_mul) begin
      dsr_r <= prod_abs[DSR_W-1:0];
      neg_r <= prod[PROD_W-1];
    end else if (cmd.do_div) begin
      dsr_r <= {rem_new, dsr_r[STEP_W-2:0], ge};
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.do_emit) begin
      ovalid_r <= 1'b1;
    end else if (out_b.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.do_emit) begin
      och_r     <= OCH_W'(ch_idx);
      opulse_r  <= new_pulse;
      olast_r   <= (ch_idx == CH_LAST);
      omoving_r <= run_r;
    end
  end

  assign out_b.valid       = ovalid_r;
  assign out_b.out_channel = och_r;
  assign out_b.pulse_out   = opulse_r;
  assign out_b.last        = olast_r;
  assign out_b.moving      = omoving_r;

endmodule

`default_nettype wire

@@ src/servo_pulse_ramp_8ch.sv @@
// Servo pulse ramp, NUM_CHANNELS channels (eight by default).
// A set beat (opcode 0) stores a target pulse for one channel and a move
// time shared by all channels; a beat with a channel out of range or a
// pulse outside 500..2500 us is dropped. The time is clamped to
// 20..30000 ms. A set beat gives no result.
// A tick beat (opcode 1) starts a pending move, advances a running ramp
// one step and reports every channel, channel 0 first, the final result
// flagged by last. Each channel runs a multiply step, the shared
// bit-serial divider while a ramp step other than the final one is in
// progress, and an emit step, in that order.
// Results leave through an output register: the next beat is taken while
// the final result of a tick still waits. When the receiver stalls, the
// sequence holds at the emit step of the next channel.
// After reset every pulse and target is 1500 us, no move runs, and the
// move time is 20 ms.
// Depends on spr_pkg, spr_in_if, spr_out_if, spr_ctrl and spr_datapath.
`default_nettype none

module servo_pulse_ramp_8ch #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spr_in_if.sink     in_b,
  spr_out_if.source  out_b
);
  import spr_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  dp_cmd_t         cmd;
  dp_status_t      status;
  logic [CH_W-1:0] ch_idx;
  logic            ready;

  // Beat sequencing.
  spr_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_b.valid),
    .in_opcode (in_b.opcode),
    .in_ready  (ready),
    .status    (status),
    .cmd       (cmd),
    .ch_idx    (ch_idx)
  );

  assign in_b.ready = ready;

  // Pulse state, ramp arithmetic and result register.
  spr_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_channel  (in_b.channel),
    .in_pulse_us (in_b.pulse_us),
    .in_move_ms  (in_b.move_ms),
    .cmd         (cmd),
    .ch_idx      (ch_idx),
    .status      (status),
    .out_b       (out_b)
  );

endmodule

`default_nettype wire

@@ sim/spr_ramp_checker.sv @@
// Scoreboard for the servo pulse ramp: watches both channels, predicts the
// eight pulse reports of every tick and compares them beat by beat.
// Depends on spr_pkg, spr_in_if and spr_out_if.
`default_nettype none

module spr_ramp_checker #(
  parameter int CHANNELS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spr_in_if         in_mon,
  spr_out_if        out_mon,
  output int        fail_count,
  output int        outstanding
);
  import spr_pkg::*;

  localparam int TICK_MS      = 20;
  localparam int REPORT_LIMIT = 10;

  // One predicted pulse report.
  typedef struct packed {
    logic [OCH_W-1:0]   channel;
    logic [PULSE_W-1:0] pulse;
    logic               last;
    logic               moving;
  } pulse_report_t;

  pulse_report_t      due_reports[$];

  // Shadow copy of the ramp state.
  logic [PULSE_W-1:0] cur_pulse [CHANNELS];
  logic [PULSE_W-1:0] tgt_pulse [CHANNELS];
  int                 start_gap [CHANNELS];
  logic [TIME_W-1:0]  ramp_ms;
  logic [STEP_W-1:0]  ramp_steps;
  logic [STEP_W-1:0]  steps_to_go;
  logic               change_waiting;
  logic               ramp_on;
  int                 mismatches;

  // Applies one accepted input beat to the shadow state and queues the
  // reports that a tick produces.
  task automatic step_ramp(input logic [OPC_W-1:0]   op,
                           input logic [CHIN_W-1:0]  ch,
                           input logic [PULSE_W-1:0] pulse,
                           input logic [MS_W-1:0]    ms);
    logic [MS_W-1:0] clamped;
    bit              done;
    int              quot;
    pulse_report_t   rep;
    if (op == OP_SET) begin
      // A set with a bad channel or pulse is dropped silently.
      if (ch < CHANNELS && pulse >= PULSE_MIN && pulse <= PULSE_MAX) begin
        clamped = ms;
        if (clamped < MS_W'(TIME_MIN)) clamped = MS_W'(TIME_MIN);
        if (clamped > MS_W'(TIME_MAX)) clamped = MS_W'(TIME_MAX);
        tgt_pulse[ch[OCH_W-1:0]] = pulse;
        ramp_ms        = clamped[TIME_W-1:0];
        change_waiting = 1'b1;
      end
    end else begin
      // A pending change restarts the ramp from the present pulses.
      if (change_waiting) begin
        change_waiting = 1'b0;
        ramp_steps     = STEP_W'(ramp_ms / TICK_MS);
        steps_to_go    = ramp_steps;
        for (int c = 0; c < CHANNELS; c++) begin
          start_gap[c] = int'(cur_pulse[c]) - int'(tgt_pulse[c]);
        end
        ramp_on = 1'b1;
      end
      // One ramp step; the quotient truncates toward zero.
      if (ramp_on) begin
        if (steps_to_go != '0) steps_to_go = steps_to_go - 1'b1;
        done = (steps_to_go == '0) || (ramp_steps == '0);
        for (int c = 0; c < CHANNELS; c++) begin
          if (done) begin
            cur_pulse[c] = tgt_pulse[c];
          end else begin
            quot = (start_gap[c] * int'(steps_to_go)) / int'(ramp_steps);
            cur_pulse[c] = PULSE_W'(int'(tgt_pulse[c]) + quot);
          end
        end
        if (done) ramp_on = 1'b0;
      end
      // Every tick reports all channels, even when nothing moves.
      for (int c = 0; c < CHANNELS; c++) begin
        rep.channel = OCH_W'(c);
        rep.pulse   = cur_pulse[c];
        rep.last    = (c == CHANNELS - 1);
        rep.moving  = ramp_on;
        due_reports.push_back(rep);
      end
    end
  endtask

  // Prediction on input beats, comparison on result beats.
  always @(posedge clk) begin
    pulse_report_t want;
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cur_pulse[c] = PULSE_RESET;
        tgt_pulse[c] = PULSE_RESET;
        start_gap[c] = 0;
      end
      ramp_ms        = TIME_MIN;
      ramp_steps     = STEP_W'(1);
      steps_to_go    = '0;
      change_waiting = 1'b0;
      ramp_on        = 1'b0;
      mismatches     = 0;
      due_reports.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        step_ramp(in_mon.opcode, in_mon.channel, in_mon.pulse_us, in_mon.move_ms);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: result beat with nothing predicted: channel %0d pulse %0d",
                     $time, out_mon.out_channel, out_mon.pulse_out);
          end
        end else begin
          want = due_reports.pop_front();
          if (out_mon.out_channel !== want.channel || out_mon.pulse_out !== want.pulse ||
              out_mon.last !== want.last || out_mon.moving !== want.moving) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: result mismatch (expected/actual): channel %0d/%0d",
                       $time, want.channel, out_mon.out_channel);
              $display("  pulse %0d/%0d last %0b/%0b moving %0b/%0b",
                       want.pulse, out_mon.pulse_out, want.last, out_mon.last,
                       want.moving, out_mon.moving);
            end
          end
        end
      end
    end
    outstanding <= due_reports.size();
    fail_count  <= mismatches;
  end

endmodule

`default_nettype wire

@@ sim/tb_servo_pulse_ramp_8ch.sv @@
// Top of the servo pulse ramp regression: clock, reset, directed and random
// set and tick beats, a randomly stalling receiver and the verdict.
// Depends on spr_pkg, spr_in_if, spr_out_if, servo_pulse_ramp_8ch, spr_ramp_checker.
`default_nettype none

module tb_servo_pulse_ramp_8ch;
  import spr_pkg::*;

  localparam int     CLK_HALF     = 6;
  localparam int     RESET_CYCLES = 7;
  localparam int     RANDOM_BEATS = 420;
  localparam int     TAIL_CYCLES  = 250;
  localparam longint RUN_LIMIT    = 64'd1_500_000 * 12;

  logic clk;
  logic rst_n;
  logic rx_ready = 1'b0;
  int   rx_hold  = 0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;
  int   fail_count;
  int   outstanding;

  spr_in_if  in_b ();
  spr_out_if out_b ();

  assign out_b.ready = rx_ready;

  servo_pulse_ramp_8ch dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_b  (in_b),
    .out_b (out_b)
  );

  spr_ramp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_b),
    .out_mon     (out_b),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Idle length: mostly none or short, now and then long.
  function automatic int gap_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // Receiver pacing: ready drops for random stretches.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      rx_ready <= 1'b0;
    end else begin
      rx_hold = gap_len(rx_quiet);
      rx_ready <= (rx_hold == 0);
      if (rx_hold > 0) rx_hold = rx_hold - 1;
    end
  end

  // Drives one input beat after a random gap and waits for its handshake.
  task automatic send_beat(input logic [OPC_W-1:0]   op,
                           input logic [CHIN_W-1:0]  ch,
                           input logic [PULSE_W-1:0] pulse,
                           input logic [MS_W-1:0]    ms);
    int n;
    n = gap_len(tx_quiet);
    if (n > 0) begin
      in_b.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_b.valid    <= 1'b1;
    in_b.opcode   <= op;
    in_b.channel  <= ch;
    in_b.pulse_us <= pulse;
    in_b.move_ms  <= ms;
    do @(posedge clk); while (!in_b.ready);
  endtask

  task automatic send_set(input logic [CHIN_W-1:0] ch, input logic [PULSE_W-1:0] pulse,
                          input logic [MS_W-1:0] ms);
    send_beat(OP_SET, ch, pulse, ms);
  endtask

  task automatic send_tick();
    send_beat(OP_TICK, CHIN_W'($urandom_range(0, 15)), PULSE_W'($urandom_range(0, 4095)),
              MS_W'($urandom()));
  endtask

  // Holds the sender off until every predicted report has arrived.
  task automatic wait_drained();
    in_b.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Stimulus and verdict.
  initial begin
    int                 beats_done;
    int                 kind;
    int                 nsets;
    int                 nticks;
    int                 steps;
    int                 r;
    logic [OPC_W-1:0]   op;
    logic [CHIN_W-1:0]  ch;
    logic [PULSE_W-1:0] pulse;
    logic [MS_W-1:0]    ms;

    rst_n         <= 1'b0;
    in_b.valid    <= 1'b0;
    in_b.opcode   <= OP_SET;
    in_b.channel  <= '0;
    in_b.pulse_us <= '0;
    in_b.move_ms  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Tick while idle: reset pulses are reported and nothing moves.
    send_tick();
    // Shortest time is clamped up; the one-step move lands at once.
    send_set(4'd0, PULSE_MIN, 16'd0);
    send_tick();
    // Longest time is clamped down, then a run of rejected sets.
    send_set(4'd7, PULSE_MAX, 16'hFFFF);
    send_set(4'd8, 12'd1000, 16'd100);
    send_set(4'd15, 12'hFFF, 16'hFFFF);
    send_set(4'd3, PULSE_MIN - 1'b1, 16'd100);
    send_set(4'd3, PULSE_MAX + 1'b1, 16'd100);
    send_set(4'd3, 12'd0, 16'd0);
    send_tick();
    send_tick();
    // A set during a move restarts the ramp from the present pulses.
    send_set(4'd2, 12'd1000, 16'd100);
    repeat (6) send_tick();
    // Times just inside and outside the clamp limits.
    send_set(4'd1, PULSE_MAX, 16'd19);
    send_set(4'd6, PULSE_MIN, 16'd30000);
    send_tick();
    send_set(4'd5, 12'd1233, 16'd40);
    send_tick();
    send_tick();
    send_set(4'd4, 12'd777, 16'd30001);
    send_tick();
    wait_drained();

    // Random part: mostly complete moves, some noise and interrupted ramps.
    beats_done = 0;
    while (beats_done < RANDOM_BEATS) begin
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
      kind     = $urandom_range(0, 9);
      if (kind < 7) begin
        nsets = $urandom_range(1, 4);
        ms    = '0;
        for (int i = 0; i < nsets; i++) begin
          r = $urandom_range(0, 9);
          if (r < 7) ms = MS_W'($urandom_range(0, 400));
          else if (r < 9) ms = MS_W'($urandom_range(400, 3000));
          else ms = MS_W'($urandom());
          ch    = CHIN_W'($urandom_range(0, 7));
          pulse = PULSE_W'($urandom_range(PULSE_MIN, PULSE_MAX));
          send_set(ch, pulse, ms);
          beats_done++;
        end
        if (ms < TIME_MIN) steps = 1;
        else if (ms > TIME_MAX) steps = TIME_MAX / 20;
        else steps = ms / 20;
        nticks = steps + $urandom_range(0, 2);
        if (nticks > 40) nticks = $urandom_range(20, 40);
        if ($urandom_range(0, 3) == 0) nticks = $urandom_range(1, nticks);
        for (int i = 0; i < nticks; i++) begin
          send_tick();
          beats_done++;
        end
      end else begin
        nsets = $urandom_range(1, 6);
        for (int i = 0; i < nsets; i++) begin
          op    = OPC_W'($urandom_range(0, 1));
          ch    = CHIN_W'($urandom_range(0, 15));
          pulse = PULSE_W'($urandom_range(0, 4095));
          send_beat(op, ch, pulse, MS_W'($urandom()));
          if (op == OP_TICK || (ch < 8 && pulse >= PULSE_MIN && pulse <= PULSE_MAX)) begin
            beats_done++;
          end
        end
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    // Drain, let the block settle, then give the verdict.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("servo_pulse_ramp_8ch regression: pass");
    end else begin
      $display("servo_pulse_ramp_8ch regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("servo_pulse_ramp_8ch regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
src/spr_pkg.sv
src/spr_in_if.sv
src/spr_out_if.sv
src/spr_ctrl.sv
src/spr_datapath.sv
src/servo_pulse_ramp_8ch.sv
sim/spr_ramp_checker.sv
sim/tb_servo_pulse_ramp_8ch.sv
